### hw/rtl/expression_token_lexer_unit_defines.svh
// ----------------------------------------------------------------------------
// expression token lexer assertion macros
// shared concurrent assertion helpers, clocked on clk_i, quiet in reset
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_TOKEN_LEXER_UNIT_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_UNIT_DEFINES_SVH

// same-cycle implication
`define ETL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("etl: same-cycle check failed");

// next-cycle implication
`define ETL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("etl: next-cycle check failed");

`endif

### hw/rtl/etl_pkg.sv
// ----------------------------------------------------------------------------
// etl_pkg
// types, codes and character constants of the expression token lexer
// ----------------------------------------------------------------------------
package etl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_EQ   = 3'd1,
    MODE_BANG = 3'd2,
    MODE_STR  = 3'd3,
    MODE_INT  = 3'd4,
    MODE_ID   = 3'd5
  } scan_mode_e;

  typedef enum logic [4:0] {
    TK_MINUS    = 5'd0,
    TK_PLUS     = 5'd1,
    TK_SLASH    = 5'd2,
    TK_STAR     = 5'd3,
    TK_SEMI     = 5'd4,
    TK_RPAREN   = 5'd5,
    TK_LPAREN   = 5'd6,
    TK_EQUAL    = 5'd7,
    TK_EQEQ     = 5'd8,
    TK_NOTEQ    = 5'd9,
    TK_STRING   = 5'd10,
    TK_INTEGER  = 5'd11,
    TK_IDENT    = 5'd12,
    TK_FUNCTION = 5'd13,
    TK_END      = 5'd14,
    TK_BAD      = 5'd15,
    TK_UNTERM   = 5'd16
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e    kind;
    logic [15:0]  start;
    logic [15:0]  length;
    logic [30:0]  value;
    logic [15:0]  line;
    logic [7:0]   bad;
  } tok_t;

  localparam int unsigned MaxTokens = 3;

  // tokens produced by one item, lowest index first
  typedef struct packed {
    logic [1:0]           cnt;
    tok_t [MaxTokens-1:0] tok;
  } tok_grp_t;

  localparam logic [30:0] VALUE_MAX = 31'h7fff_ffff;
  localparam logic [15:0] LINE_MAX  = 16'hffff;

  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
  endfunction

endpackage

### hw/rtl/etl_scan.sv
// ----------------------------------------------------------------------------
// etl_scan
// scanner state registers and the single-pass token logic for one item
// ----------------------------------------------------------------------------
module etl_scan import etl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       commit_i,
  input  logic [7:0] char_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_source_i,
  output tok_grp_t   grp_o
);

  localparam int unsigned PB = POSITION_BITS;

  scan_mode_e  mode_q, mode_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [PB-1:0] org_q, org_d;
  logic [15:0] line_q, line_d;
  logic [30:0] acc_q, acc_d;

  tok_t [MaxTokens-1:0] toks;
  logic [1:0]  n;
  logic        do_idle;
  logic [7:0]  c;
  logic [7:0]  dig;
  logic [34:0] v;

  function automatic logic [15:0] to16(input logic [PB-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[15:0];
  endfunction

  function automatic tok_t mk_tok(input tok_kind_e k, input logic [PB-1:0] s,
                                  input logic [PB-1:0] l, input logic [30:0] val,
                                  input logic [15:0] ln, input logic [7:0] b);
    tok_t t;
    t.kind   = k;
    t.start  = to16(s);
    t.length = to16(l);
    t.value  = val;
    t.line   = ln;
    t.bad    = b;
    return t;
  endfunction

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    org_d   = org_q;
    line_d  = line_q;
    acc_d   = acc_q;
    toks    = '0;
    n       = 2'd0;
    do_idle = 1'b0;
    c       = char_byte_i;
    dig     = c - CH_0;
    v       = 35'({acc_q, 3'b000}) + 35'({acc_q, 1'b0}) + 35'(dig);

    if (byte_present_i) begin
      // resolve whatever is pending against this byte
      unique case (mode_d)
        MODE_EQ: begin
          mode_d = MODE_IDLE;
          if (c == CH_EQ) begin
            toks[n] = mk_tok(TK_EQEQ, org_d, PB'(2), '0, line_d, '0);
            n = n + 2'd1;
          end else begin
            toks[n] = mk_tok(TK_EQUAL, org_d, PB'(1), '0, line_d, '0);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_BANG: begin
          mode_d = MODE_IDLE;
          if (c == CH_EQ) begin
            toks[n] = mk_tok(TK_NOTEQ, org_d, PB'(2), '0, line_d, '0);
            n = n + 2'd1;
          end else begin
            toks[n] = mk_tok(TK_BAD, org_d, PB'(1), '0, line_d, CH_BANG);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            toks[n] = mk_tok(TK_STRING, org_d + PB'(1), pos_d - org_d - PB'(1),
                             '0, line_d, '0);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else if (c == CH_NL) begin
            if (line_d != LINE_MAX) line_d = line_d + 16'd1;
          end
        end
        MODE_INT: begin
          if (is_digit(c)) begin
            acc_d = (v > 35'(VALUE_MAX)) ? VALUE_MAX : v[30:0];
          end else begin
            toks[n] = mk_tok(TK_INTEGER, org_d, pos_d - org_d, acc_d, line_d, '0);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
            do_idle = 1'b1;
          end
        end
        MODE_ID: begin
          if (!(is_alpha(c) || is_digit(c))) begin
            toks[n] = mk_tok((c == CH_LPAREN) ? TK_FUNCTION : TK_IDENT, org_d,
                             pos_d - org_d, '0, line_d, '0);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
            do_idle = 1'b1;
          end
        end
        default: begin
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      endcase

      // scan the byte from idle
      if (do_idle) begin
        org_d = pos_d;
        unique case (c)
          CH_MINUS: begin
            toks[n] = mk_tok(TK_MINUS, org_d, PB'(1), '0, line_d, '0);
            n = n + 2'd1;
          end
          CH_PLUS: begin
            toks[n] = mk_tok(TK_PLUS, org_d, PB'(1), '0, line_d, '0);
            n = n + 2'd1;
          end
          CH_SLASH: begin
            toks[n] = mk_tok(TK_SLASH, org_d, PB'(1), '0, line_d, '0);
            n = n + 2'd1;
          end
          CH_STAR: begin
            toks[n] = mk_tok(TK_STAR, org_d, PB'(1), '0, line_d, '0);
            n = n + 2'd1;
          end
          CH_SEMI: begin
            toks[n] = mk_tok(TK_SEMI, org_d, PB'(1), '0, line_d, '0);
            n = n + 2'd1;
          end
          CH_RPAREN: begin
            toks[n] = mk_tok(TK_RPAREN, org_d, PB'(1), '0, line_d, '0);
            n = n + 2'd1;
          end
          CH_LPAREN: begin
            toks[n] = mk_tok(TK_LPAREN, org_d, PB'(1), '0, line_d, '0);
            n = n + 2'd1;
          end
          CH_EQ:    mode_d = MODE_EQ;
          CH_BANG:  mode_d = MODE_BANG;
          CH_QUOTE: mode_d = MODE_STR;
          CH_SPACE: ;
          CH_NL: begin
            if (line_d != LINE_MAX) line_d = line_d + 16'd1;
          end
          default: begin
            if (is_digit(c)) begin
              acc_d  = 31'(dig);
              mode_d = MODE_INT;
            end else if (is_alpha(c)) begin
              mode_d = MODE_ID;
            end else begin
              toks[n] = mk_tok(TK_BAD, org_d, PB'(1), '0, line_d, c);
              n = n + 2'd1;
            end
          end
        endcase
      end
      pos_d = pos_d + PB'(1);
    end

    if (end_of_source_i) begin
      // flush the pending token, then close with an end token if fewer than three
      unique case (mode_d)
        MODE_EQ: begin
          toks[n] = mk_tok(TK_EQUAL, org_d, PB'(1), '0, line_d, '0);
          n = n + 2'd1;
        end
        MODE_BANG: begin
          toks[n] = mk_tok(TK_BAD, org_d, PB'(1), '0, line_d, CH_BANG);
          n = n + 2'd1;
        end
        MODE_STR: begin
          toks[n] = mk_tok(TK_UNTERM, org_d + PB'(1), pos_d - org_d - PB'(1),
                           '0, line_d, '0);
          n = n + 2'd1;
        end
        MODE_INT: begin
          toks[n] = mk_tok(TK_INTEGER, org_d, pos_d - org_d, acc_d, line_d, '0);
          n = n + 2'd1;
        end
        MODE_ID: begin
          toks[n] = mk_tok(TK_IDENT, org_d, pos_d - org_d, '0, line_d, '0);
          n = n + 2'd1;
        end
        default: ;
      endcase
      if (n != 2'd3) toks[n] = mk_tok(TK_END, pos_d, '0, '0, line_d, '0);
      n = n + 2'd1;
      mode_d = MODE_IDLE;
      pos_d  = '0;
      org_d  = '0;
      line_d = 16'd1;
      acc_d  = '0;
    end
  end

  assign grp_o.cnt = n;
  assign grp_o.tok = toks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
      org_q  <= '0;
      line_q <= 16'd1;
      acc_q  <= '0;
    end else if (commit_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      org_q  <= org_d;
      line_q <= line_d;
      acc_q  <= acc_d;
    end
  end

endmodule

### hw/rtl/etl_tokq.sv
// ----------------------------------------------------------------------------
// etl_tokq
// result register for one item's tokens, sent one per cycle while out_ready_i
// ----------------------------------------------------------------------------
module etl_tokq import etl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  tok_grp_t grp_i,
  output logic     free_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tok_t     head_o,
  output logic     last_o
);

  logic [1:0]           cnt_q, cnt_d;
  tok_t [MaxTokens-1:0] tok_q, tok_d;
  logic                 take;

  assign take        = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign last_o      = (cnt_q == 2'd1);
  assign free_o      = (cnt_q == 2'd0) || (last_o && out_ready_i);
  assign head_o      = tok_q[0];

  always_comb begin
    cnt_d = cnt_q;
    tok_d = tok_q;
    if (load_i) begin
      cnt_d = grp_i.cnt;
      tok_d = grp_i.tok;
    end else if (take) begin
      cnt_d    = cnt_q - 2'd1;
      tok_d[0] = tok_q[1];
      tok_d[1] = tok_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

endmodule

### hw/rtl/expression_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// expression_token_lexer_unit
// streaming lexer: source bytes in, operator, string, integer, identifier,
// function, end and error tokens out
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    char_byte, byte_present,
//                                                 end_of_source
//  out      source     out_valid_o / out_ready_i  token_kind .. last_of_run
//
//  an item is held in the input register, then its tokens are built
//  in one pass and loaded into the result register (up to three tokens)
//  the result register hands out one token per cycle while out_ready_i
//  is high, so an item holds it until its last token is taken; items
//  making none or one token flow at one per cycle while out_ready_i is high
//  a new item is taken while the last token of the previous one is taken
//  reset clears scanner state to idle, offset 0, line 1; no clearing pass
//  stalls on out back up into the input register and then to in_ready_o
// ----------------------------------------------------------------------------
`include "expression_token_lexer_unit_defines.svh"

module expression_token_lexer_unit import etl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [30:0] int_value_o,
  output logic [15:0] line_number_o,
  output logic [7:0]  bad_byte_o,
  output logic        last_of_run_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] char_q;
  logic       present_q;
  logic       eos_q;

  logic       commit;
  logic       grp_free;
  tok_grp_t   grp;
  tok_t       head;

  // item leaves the input register once the result register can take its tokens
  assign commit     = in_vld_q && grp_free;
  assign in_ready_o = !in_vld_q || commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q    <= char_byte_i;
      present_q <= byte_present_i;
      eos_q     <= end_of_source_i;
    end
  end

  // scanner: mode, offsets, line counter, integer accumulator
  etl_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .commit_i       (commit),
    .char_byte_i    (char_q),
    .byte_present_i (present_q),
    .end_of_source_i(eos_q),
    .grp_o          (grp)
  );

  // result register, drained one token per cycle while out_ready_i is high
  etl_tokq u_tokq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (commit),
    .grp_i      (grp),
    .free_o     (grp_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head),
    .last_o     (last_of_run_o)
  );

  assign token_kind_o   = head.kind;
  assign token_start_o  = head.start;
  assign token_length_o = head.length;
  assign int_value_o    = head.value;
  assign line_number_o  = head.line;
  assign bad_byte_o     = head.bad;

  // a stalled input always has tokens waiting ahead of it
  `ETL_ASSERT_NOW(a_stall_has_output, !in_ready_o, out_valid_o)
  // the end token closes the run of its item
  `ETL_ASSERT_NOW(a_end_is_last, out_valid_o && (token_kind_o == TK_END), last_of_run_o)
  // tokens of one item follow each other without a gap
  `ETL_ASSERT_NEXT(a_run_continues, out_valid_o && out_ready_i && !last_of_run_o,
                   out_valid_o)

endmodule
